[rtl/core/mmfc_pkg.sv]
// ----------------------------------------------------------------------------
// mmfc_pkg
// shared types, register codes and constants of the motor frame codec
// ----------------------------------------------------------------------------
package mmfc_pkg;

  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned DIV_BITS      = 16;
  localparam int unsigned LATENCY       = DIV_BITS + 4;
  localparam int unsigned NUM_LANES     = 5;

  typedef enum logic [2:0] {
    OP_FEEDBACK = 3'd0,
    OP_COMMAND  = 3'd1,
    OP_ENTER    = 3'd2,
    OP_EXIT     = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_SAVE     = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    REG_ANGLE  = 3'd0,
    REG_SPEED  = 3'd1,
    REG_TORQUE = 3'd2,
    REG_STIFF  = 3'd3,
    REG_DAMP   = 3'd4,
    REG_MOTOR  = 3'd5,
    REG_BASE   = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_DROPPED = 2'd0,
    KIND_DECODED = 2'd1,
    KIND_TX      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    QM_ZERO = 2'd0,
    QM_MAX  = 2'd1,
    QM_DIV  = 2'd2
  } qmode_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [63:0]        rx_frame;
    logic signed [31:0] cmd_angle;
    logic signed [31:0] cmd_speed;
    logic signed [31:0] cmd_torque;
    logic signed [31:0] cmd_stiffness;
    logic signed [31:0] cmd_damping;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [10:0]        tx_id;
    logic [63:0]        tx_data;
    logic signed [31:0] fb_angle;
    logic signed [31:0] fb_speed;
    logic signed [31:0] fb_torque;
  } res_t;

  localparam logic [7:0] LAST_ENTER = 8'hFC;
  localparam logic [7:0] LAST_EXIT  = 8'hFD;
  localparam logic [7:0] LAST_CLEAR = 8'hFB;
  localparam logic [7:0] LAST_SAVE  = 8'hFE;
  localparam logic [55:0] FILL_BYTES = 56'hFF_FFFF_FFFF_FFFF;

  function automatic logic [30:0] sat31(input logic [63:0] v);
    logic [30:0] r;
    r = (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
    return r;
  endfunction

  localparam logic [63:0] ANGLE_RAW  = (64'd25 << FRACTION_BITS) / 64'd2;
  localparam logic [63:0] SPEED_RAW  = (64'd30 << FRACTION_BITS);
  localparam logic [63:0] TORQUE_RAW = (64'd10 << FRACTION_BITS);
  localparam logic [63:0] STIFF_RAW  = (64'd500 << FRACTION_BITS);
  localparam logic [63:0] DAMP_RAW   = (64'd5 << FRACTION_BITS);

  localparam logic [30:0] ANGLE_RST  = sat31(ANGLE_RAW);
  localparam logic [30:0] SPEED_RST  = sat31(SPEED_RAW);
  localparam logic [30:0] TORQUE_RST = sat31(TORQUE_RAW);
  localparam logic [30:0] STIFF_RST  = sat31(STIFF_RAW);
  localparam logic [30:0] DAMP_RST   = sat31(DAMP_RAW);
  localparam logic [3:0]  MOTOR_RST  = 4'd1;
  localparam logic [10:0] BASE_RST   = 11'd0;

endpackage

[rtl/core/mmfc_qdiv.sv]
// ----------------------------------------------------------------------------
// mmfc_qdiv
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module mmfc_qdiv (
  input  logic        clk_i,
  input  logic [47:0] num_i,
  input  logic [31:0] den_i,
  output logic [15:0] quo_o
);

  logic [31:0] rem_q [mmfc_pkg::DIV_BITS];
  logic [15:0] low_q [mmfc_pkg::DIV_BITS];
  logic [31:0] den_q [mmfc_pkg::DIV_BITS];
  logic [15:0] quo_q [mmfc_pkg::DIV_BITS];

  for (genvar i = 0; i < mmfc_pkg::DIV_BITS; i++) begin : g_stage
    logic [31:0] rem_in;
    logic [15:0] low_in;
    logic [31:0] den_in;
    logic [15:0] quo_in;
    logic [32:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in = num_i[47:16];
      assign low_in = num_i[15:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign trial = {rem_in, low_in[15]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
      low_q[i] <= {low_in[14:0], 1'b0};
      den_q[i] <= den_in;
      quo_q[i] <= {quo_in[14:0], ge};
    end
  end

  assign quo_o = quo_q[mmfc_pkg::DIV_BITS-1];

endmodule

[rtl/core/mit_motor_frame_codec.sv]
// ----------------------------------------------------------------------------
// mit_motor_frame_codec
// MIT-mode motor frame codec: command quantise and pack, feedback decode
// ----------------------------------------------------------------------------
// command channel: an item (cmd_i) is taken at each edge with start_i high and
//   busy_o low; busy_o stays low, so one item can enter every cycle
// result channel: res_o is shown for one cycle with res_valid_o high; there
//   is no back-pressure, the receiver takes every result as it appears
// pipeline: an accepted item passes through
//   3 input and prepare stages, 16 divider stages and 1 output register;
//   throughput is one item per cycle, set by the bit-per-stage dividers
// ops 6 and 7 give no result; feedback for another motor gives kind 0
// configuration: cfg_index_i / cfg_data_i written when cfg_valid_i is high
//   (cfg_ready_o is always high); write only while no item is in flight
// reset: limits and ids take their defaults, all pipeline valid bits clear
// ----------------------------------------------------------------------------
module mit_motor_frame_codec (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  mmfc_pkg::cmd_t       cmd_i,
  output logic                 res_valid_o,
  output mmfc_pkg::res_t       res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  typedef struct packed {
    mmfc_pkg::qmode_e mode;
    logic [31:0]      off;
    logic [31:0]      span;
  } qlane_t;

  typedef struct packed {
    logic [31:0] q;
    logic [32:0] s;
  } fold_t;

  typedef struct packed {
    mmfc_pkg::kind_e kind;
    logic            is_cmd;
    logic [63:0]     fixed;
    logic [10:0]     tx_id;
  } hdr_t;

  typedef struct packed {
    hdr_t               hdr;
    mmfc_pkg::qmode_e   mode_a;
    mmfc_pkg::qmode_e   mode_v;
    mmfc_pkg::qmode_e   mode_t;
    mmfc_pkg::qmode_e   mode_kp;
    mmfc_pkg::qmode_e   mode_kd;
    logic signed [31:0] fb_a;
    logic signed [31:0] fb_v;
    logic signed [31:0] fb_t;
  } side_t;

  // configuration
  logic [30:0] angle_lim_q, speed_lim_q, torque_lim_q, stiff_lim_q, damp_lim_q;
  logic [3:0]  motor_q;
  logic [10:0] base_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_lim_q  <= mmfc_pkg::ANGLE_RST;
      speed_lim_q  <= mmfc_pkg::SPEED_RST;
      torque_lim_q <= mmfc_pkg::TORQUE_RST;
      stiff_lim_q  <= mmfc_pkg::STIFF_RST;
      damp_lim_q   <= mmfc_pkg::DAMP_RST;
      motor_q      <= mmfc_pkg::MOTOR_RST;
      base_q       <= mmfc_pkg::BASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mmfc_pkg::reg_idx_e'(cfg_index_i))
        mmfc_pkg::REG_ANGLE:  angle_lim_q  <= cfg_data_i[30:0];
        mmfc_pkg::REG_SPEED:  speed_lim_q  <= cfg_data_i[30:0];
        mmfc_pkg::REG_TORQUE: torque_lim_q <= cfg_data_i[30:0];
        mmfc_pkg::REG_STIFF:  stiff_lim_q  <= cfg_data_i[30:0];
        mmfc_pkg::REG_DAMP:   damp_lim_q   <= cfg_data_i[30:0];
        mmfc_pkg::REG_MOTOR:  motor_q      <= cfg_data_i[3:0];
        mmfc_pkg::REG_BASE:   base_q       <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  function automatic qlane_t prep(input logic signed [31:0] x, input logic [30:0] lim,
                                  input logic sym);
    qlane_t             r;
    logic signed [33:0] off;
    logic [31:0]        span;
    off  = sym ? (34'(x) + $signed({3'b0, lim})) : 34'(x);
    span = sym ? {lim, 1'b0} : {1'b0, lim};
    r.off  = off[31:0];
    r.span = span;
    if (off <= 34'sd0) begin
      r.mode = mmfc_pkg::QM_ZERO;
    end else if (off >= $signed({2'b0, span})) begin
      r.mode = mmfc_pkg::QM_MAX;
    end else begin
      r.mode = mmfc_pkg::QM_DIV;
    end
    return r;
  endfunction

  // x / (2^k - 1) by folding the high part back onto the low part
  function automatic fold_t fold1(input logic [47:0] x, input int unsigned k);
    fold_t       r;
    logic [47:0] hi;
    logic [47:0] lo;
    hi  = x >> k;
    lo  = x & ((48'd1 << k) - 48'd1);
    r.q = hi[31:0];
    r.s = 33'(hi) + 33'(lo);
    return r;
  endfunction

  function automatic logic [31:0] fold_rest(input fold_t f, input int unsigned k,
                                            input logic [30:0] lim);
    logic [32:0] mask, h2, l2, s2, h3, l3, s3, q;
    mask = (33'd1 << k) - 33'd1;
    h2   = f.s >> k;
    l2   = f.s & mask;
    s2   = h2 + l2;
    h3   = s2 >> k;
    l3   = s2 & mask;
    s3   = h3 + l3;
    q    = {1'b0, f.q} + h2 + h3;
    if (s3 >= mask) begin
      q = q + 33'd1;
    end
    return q[31:0] - {1'b0, lim};
  endfunction

  // stage 1: input register
  logic           s1_valid_q;
  mmfc_pkg::cmd_t s1_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      s1_cmd_q <= cmd_i;
    end
  end

  // stage 2: offsets, saturation decisions, feedback products
  logic        s2_valid_d, s2_valid_q;
  hdr_t        s2_hdr_d, s2_hdr_q;
  qlane_t      s2_lane_d [mmfc_pkg::NUM_LANES];
  qlane_t      s2_lane_q [mmfc_pkg::NUM_LANES];
  logic [47:0] s2_prod_d [3];
  logic [47:0] s2_prod_q [3];

  always_comb begin
    logic [63:0] fr;
    logic [7:0]  last;
    fr   = s1_cmd_q.rx_frame;
    last = mmfc_pkg::LAST_SAVE;
    case (s1_cmd_q.op)
      mmfc_pkg::OP_ENTER: last = mmfc_pkg::LAST_ENTER;
      mmfc_pkg::OP_EXIT:  last = mmfc_pkg::LAST_EXIT;
      mmfc_pkg::OP_CLEAR: last = mmfc_pkg::LAST_CLEAR;
      default:            last = mmfc_pkg::LAST_SAVE;
    endcase
    s2_valid_d      = s1_valid_q && (s1_cmd_q.op <= mmfc_pkg::OP_SAVE);
    s2_hdr_d.is_cmd = s1_cmd_q.op == mmfc_pkg::OP_COMMAND;
    s2_hdr_d.fixed  = {mmfc_pkg::FILL_BYTES, last};
    s2_hdr_d.tx_id  = base_q | {7'b0, motor_q};
    if (s1_cmd_q.op == mmfc_pkg::OP_FEEDBACK) begin
      s2_hdr_d.kind = (fr[59:56] == motor_q) ? mmfc_pkg::KIND_DECODED
                                             : mmfc_pkg::KIND_DROPPED;
    end else begin
      s2_hdr_d.kind = mmfc_pkg::KIND_TX;
    end
    s2_lane_d[0] = prep(s1_cmd_q.cmd_angle, angle_lim_q, 1'b1);
    s2_lane_d[1] = prep(s1_cmd_q.cmd_speed, speed_lim_q, 1'b1);
    s2_lane_d[2] = prep(s1_cmd_q.cmd_torque, torque_lim_q, 1'b1);
    s2_lane_d[3] = prep(s1_cmd_q.cmd_stiffness, stiff_lim_q, 1'b0);
    s2_lane_d[4] = prep(s1_cmd_q.cmd_damping, damp_lim_q, 1'b0);
    s2_prod_d[0] = 48'(fr[55:40]) * 48'({angle_lim_q, 1'b0});
    s2_prod_d[1] = 48'(fr[39:28]) * 48'({speed_lim_q, 1'b0});
    s2_prod_d[2] = 48'(fr[27:16]) * 48'({torque_lim_q, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_hdr_q  <= s2_hdr_d;
    s2_lane_q <= s2_lane_d;
    s2_prod_q <= s2_prod_d;
  end

  // stage 3: numerators and first fold of the feedback division
  logic             s3_valid_q;
  hdr_t             s3_hdr_q;
  logic [47:0]      s3_num_q  [mmfc_pkg::NUM_LANES];
  logic [31:0]      s3_den_q  [mmfc_pkg::NUM_LANES];
  mmfc_pkg::qmode_e s3_mode_q [mmfc_pkg::NUM_LANES];
  fold_t            s3_fold_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_hdr_q <= s2_hdr_q;
    for (int i = 0; i < mmfc_pkg::NUM_LANES; i++) begin
      s3_num_q[i]  <= (i == 0) ? 48'(s2_lane_q[i].off) * 48'(16'hFFFF)
                               : 48'(s2_lane_q[i].off) * 48'(12'hFFF);
      s3_den_q[i]  <= s2_lane_q[i].span;
      s3_mode_q[i] <= s2_lane_q[i].mode;
    end
    s3_fold_q[0] <= fold1(s2_prod_q[0], 16);
    s3_fold_q[1] <= fold1(s2_prod_q[1], 12);
    s3_fold_q[2] <= fold1(s2_prod_q[2], 12);
  end

  // divider lanes
  logic [15:0] quo [mmfc_pkg::NUM_LANES];

  for (genvar g = 0; g < mmfc_pkg::NUM_LANES; g++) begin : g_lane
    mmfc_qdiv u_div (
      .clk_i (clk_i),
      .num_i (s3_num_q[g]),
      .den_i (s3_den_q[g]),
      .quo_o (quo[g])
    );
  end

  // side line alongside the dividers
  side_t side_d;
  side_t side_q  [mmfc_pkg::DIV_BITS];
  logic  sidev_q [mmfc_pkg::DIV_BITS];

  always_comb begin
    logic dec;
    dec             = s3_hdr_q.kind == mmfc_pkg::KIND_DECODED;
    side_d.hdr      = s3_hdr_q;
    side_d.mode_a   = s3_mode_q[0];
    side_d.mode_v   = s3_mode_q[1];
    side_d.mode_t   = s3_mode_q[2];
    side_d.mode_kp  = s3_mode_q[3];
    side_d.mode_kd  = s3_mode_q[4];
    side_d.fb_a     = dec ? fold_rest(s3_fold_q[0], 16, angle_lim_q) : '0;
    side_d.fb_v     = dec ? fold_rest(s3_fold_q[1], 12, speed_lim_q) : '0;
    side_d.fb_t     = dec ? fold_rest(s3_fold_q[2], 12, torque_lim_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mmfc_pkg::DIV_BITS; i++) begin
        sidev_q[i] <= 1'b0;
      end
    end else begin
      sidev_q[0] <= s3_valid_q;
      for (int i = 1; i < mmfc_pkg::DIV_BITS; i++) begin
        sidev_q[i] <= sidev_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < mmfc_pkg::DIV_BITS; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // output assembly
  function automatic logic [15:0] pick(input mmfc_pkg::qmode_e m, input logic [15:0] q,
                                       input logic [15:0] maxc);
    logic [15:0] r;
    case (m)
      mmfc_pkg::QM_ZERO: r = '0;
      mmfc_pkg::QM_MAX:  r = maxc;
      default:           r = q;
    endcase
    return r;
  endfunction

  side_t          last_s;
  logic [15:0]    c_a, c_v, c_t, c_kp, c_kd;
  mmfc_pkg::res_t res_d, res_q;
  logic           res_valid_q;

  assign last_s = side_q[mmfc_pkg::DIV_BITS-1];

  always_comb begin
    c_a  = pick(last_s.mode_a, quo[0], 16'hFFFF);
    c_v  = pick(last_s.mode_v, quo[1], 16'h0FFF);
    c_t  = pick(last_s.mode_t, quo[2], 16'h0FFF);
    c_kp = pick(last_s.mode_kp, quo[3], 16'h0FFF);
    c_kd = pick(last_s.mode_kd, quo[4], 16'h0FFF);
    res_d.kind      = last_s.hdr.kind;
    res_d.fb_angle  = last_s.fb_a;
    res_d.fb_speed  = last_s.fb_v;
    res_d.fb_torque = last_s.fb_t;
    if (last_s.hdr.kind == mmfc_pkg::KIND_TX) begin
      res_d.tx_id   = last_s.hdr.tx_id;
      res_d.tx_data = last_s.hdr.is_cmd
                    ? {c_a, c_v[11:0], c_kp[11:0], c_kd[11:0], c_t[11:0]}
                    : last_s.hdr.fixed;
    end else begin
      res_d.tx_id   = '0;
      res_d.tx_data = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= sidev_q[mmfc_pkg::DIV_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cmd_i.op <= mmfc_pkg::OP_SAVE)
    |-> ##(mmfc_pkg::LATENCY) res_valid_o)
    else $error("accepted transaction gave no result");

  a_unknown_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cmd_i.op > mmfc_pkg::OP_SAVE)
    |-> ##(mmfc_pkg::LATENCY) !res_valid_o)
    else $error("unknown op gave a result");

  a_tx_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind != mmfc_pkg::KIND_TX)
    |-> (res_o.tx_data == '0) && (res_o.tx_id == '0))
    else $error("transmit fields set on feedback result");

  a_fb_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind != mmfc_pkg::KIND_DECODED)
    |-> (res_o.fb_angle == '0) && (res_o.fb_speed == '0) && (res_o.fb_torque == '0))
    else $error("feedback fields set on non-decoded result");

endmodule

[verif/mmfc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfc_checker
// watches the command, configuration and result channels of the motor frame
// codec, predicts every result in order and compares it field by field
// ----------------------------------------------------------------------------
module mmfc_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  mmfc_pkg::cmd_t cmd_i,
  input  logic           res_valid_i,
  input  mmfc_pkg::res_t res_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  logic [30:0]    angle_lim, speed_lim, torque_lim, stiff_lim, damp_lim;
  logic [3:0]     motor_nib;
  logic [10:0]    base_nib;
  mmfc_pkg::res_t frame_q[$];

  assign pending_o = frame_q.size();

  function automatic logic [15:0] to_code(input longint off, input longint span,
                                          input longint maxcode);
    longint q;
    if (off <= 0) return '0;
    if (span == 0) return maxcode[15:0];
    q = (off * maxcode) / span;
    return (q >= maxcode) ? maxcode[15:0] : q[15:0];
  endfunction

  function automatic logic [31:0] from_code(input longint code, input logic [30:0] lim,
                                            input longint maxcode);
    longint v;
    v = (code * 2 * longint'(lim)) / maxcode - longint'(lim);
    return v[31:0];
  endfunction

  function automatic mmfc_pkg::res_t encode_frame(input mmfc_pkg::cmd_t c);
    mmfc_pkg::res_t r;
    logic [15:0] a, s, t, kp, kd;
    logic [7:0] last;
    r = '0;
    if (c.op == mmfc_pkg::OP_FEEDBACK) begin
      r.kind = mmfc_pkg::KIND_DROPPED;
      if (c.rx_frame[59:56] == motor_nib) begin
        r.kind = mmfc_pkg::KIND_DECODED;
        r.fb_angle  = from_code(c.rx_frame[55:40], angle_lim, 65535);
        r.fb_speed  = from_code(c.rx_frame[39:28], speed_lim, 4095);
        r.fb_torque = from_code(c.rx_frame[27:16], torque_lim, 4095);
      end
      return r;
    end
    r.kind  = mmfc_pkg::KIND_TX;
    r.tx_id = base_nib | {7'd0, motor_nib};
    if (c.op == mmfc_pkg::OP_COMMAND) begin
      a  = to_code(longint'(c.cmd_angle) + angle_lim, 2 * longint'(angle_lim), 65535);
      s  = to_code(longint'(c.cmd_speed) + speed_lim, 2 * longint'(speed_lim), 4095);
      t  = to_code(longint'(c.cmd_torque) + torque_lim, 2 * longint'(torque_lim), 4095);
      kp = to_code(longint'(c.cmd_stiffness), longint'(stiff_lim), 4095);
      kd = to_code(longint'(c.cmd_damping), longint'(damp_lim), 4095);
      r.tx_data = {a, s[11:0], kp[11:0], kd[11:0], t[11:0]};
    end else begin
      case (c.op)
        mmfc_pkg::OP_ENTER: last = mmfc_pkg::LAST_ENTER;
        mmfc_pkg::OP_EXIT:  last = mmfc_pkg::LAST_EXIT;
        mmfc_pkg::OP_CLEAR: last = mmfc_pkg::LAST_CLEAR;
        default:            last = mmfc_pkg::LAST_SAVE;
      endcase
      r.tx_data = {mmfc_pkg::FILL_BYTES, last};
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mmfc_pkg::res_t want;
    if (!rst_ni) begin
      angle_lim    <= mmfc_pkg::ANGLE_RST;
      speed_lim    <= mmfc_pkg::SPEED_RST;
      torque_lim   <= mmfc_pkg::TORQUE_RST;
      stiff_lim    <= mmfc_pkg::STIFF_RST;
      damp_lim     <= mmfc_pkg::DAMP_RST;
      motor_nib    <= mmfc_pkg::MOTOR_RST;
      base_nib     <= mmfc_pkg::BASE_RST;
      fail_count_o <= 0;
      frame_q.delete();
    end else begin
      if (res_valid_i) begin
        if (frame_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = frame_q.pop_front();
          if (res_i.kind !== want.kind || res_i.tx_id !== want.tx_id ||
              res_i.tx_data !== want.tx_data || res_i.fb_angle !== want.fb_angle ||
              res_i.fb_speed !== want.fb_speed || res_i.fb_torque !== want.fb_torque) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, res_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i && cmd_i.op <= mmfc_pkg::OP_SAVE)
        frame_q.push_back(encode_frame(cmd_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (mmfc_pkg::reg_idx_e'(cfg_index_i))
          mmfc_pkg::REG_ANGLE:  angle_lim  <= cfg_data_i[30:0];
          mmfc_pkg::REG_SPEED:  speed_lim  <= cfg_data_i[30:0];
          mmfc_pkg::REG_TORQUE: torque_lim <= cfg_data_i[30:0];
          mmfc_pkg::REG_STIFF:  stiff_lim  <= cfg_data_i[30:0];
          mmfc_pkg::REG_DAMP:   damp_lim   <= cfg_data_i[30:0];
          mmfc_pkg::REG_MOTOR:  motor_nib  <= cfg_data_i[3:0];
          mmfc_pkg::REG_BASE:   base_nib   <= cfg_data_i[10:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[verif/tb_mit_motor_frame_codec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mit_motor_frame_codec
// drives directed and random commands and feedback frames through the codec
// across several register settings; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_mit_motor_frame_codec;

  logic           clk, rst_n, start, busy, res_valid, cfg_valid, cfg_ready;
  mmfc_pkg::cmd_t cmd;
  mmfc_pkg::res_t res;
  logic [2:0]     cfg_index;
  logic [31:0]    cfg_data;
  int             fail_count, pending;
  logic [3:0]     cur_motor;
  int             cycles;
  bit             quiet;

  mit_motor_frame_codec dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .cmd_i(cmd), .res_valid_o(res_valid), .res_o(res),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  mmfc_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .cmd_i(cmd),
    .res_valid_i(res_valid), .res_i(res), .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(input mmfc_pkg::reg_idx_e idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == mmfc_pkg::REG_MOTOR) cur_motor = val[3:0];
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (mmfc_pkg::LATENCY + 4) @(negedge clk);
  endtask

  task automatic send(input mmfc_pkg::cmd_t c);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 10) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic mmfc_pkg::cmd_t rand_item();
    mmfc_pkg::cmd_t c;
    c = '0;
    c.op = mmfc_pkg::op_e'($urandom_range(0, 5));
    if ($urandom_range(0, 49) == 0) c.op = 3'($urandom_range(6, 7));
    c.rx_frame = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) != 0) c.rx_frame[59:56] = cur_motor;
    c.cmd_angle     = rand_word();
    c.cmd_speed     = rand_word();
    c.cmd_torque    = rand_word();
    c.cmd_stiffness = rand_word();
    c.cmd_damping   = rand_word();
    return c;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      quiet = (i >= n / 3 && i < n / 2);
      send(rand_item());
    end
    quiet = 1'b0;
    start <= 1'b0;
  endtask

  initial begin
    mmfc_pkg::cmd_t c;
    start = 1'b0; cmd = '0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    cur_motor = mmfc_pkg::MOTOR_RST; quiet = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: every op, field extremes, ignored ops, mismatched feedback
    for (int op = 0; op < 8; op++) begin
      c = '0;
      c.op = 3'(op);
      c.rx_frame = {8'h01, 56'hFF_FFFF_FFFF_FFFF};
      send(c);
    end
    for (int k = 0; k < 4; k++) begin
      c = '0;
      c.op = mmfc_pkg::OP_COMMAND;
      c.cmd_angle = (k == 0) ? 32'h8000_0000 : (k == 1) ? 32'h7FFF_FFFF :
                    (k == 2) ? -32'(mmfc_pkg::ANGLE_RST) : 32'(mmfc_pkg::ANGLE_RST);
      c.cmd_speed = c.cmd_angle; c.cmd_torque = c.cmd_angle;
      c.cmd_stiffness = c.cmd_angle; c.cmd_damping = c.cmd_angle;
      send(c);
      c = '0;
      c.op = mmfc_pkg::OP_FEEDBACK;
      c.rx_frame = (k == 0) ? {8'hF1, 56'h0} : (k == 1) ? {8'h01, {56{1'b1}}} :
                   (k == 2) ? {8'h00, 56'h12_3456_789A_BCDE} : {8'hF1, 56'h80_0800_8000_00};
      send(c);
    end
    random_phase(250);

    // wait for every result before retuning
    drain();
    write_reg(mmfc_pkg::REG_ANGLE, 32'h7FFF_FFFF);
    write_reg(mmfc_pkg::REG_SPEED, 32'd1);
    write_reg(mmfc_pkg::REG_TORQUE, 32'hFFFF_FFFF);
    write_reg(mmfc_pkg::REG_STIFF, 32'h7FFF_FFFF);
    write_reg(mmfc_pkg::REG_DAMP, 32'd1);
    write_reg(mmfc_pkg::REG_MOTOR, 32'd15);
    write_reg(mmfc_pkg::REG_BASE, 32'd2047);
    random_phase(250);

    drain();
    write_reg(mmfc_pkg::REG_ANGLE, 32'd0);
    write_reg(mmfc_pkg::REG_SPEED, 32'h8000_0000);
    write_reg(mmfc_pkg::REG_TORQUE, 32'd1);
    write_reg(mmfc_pkg::REG_STIFF, 32'd0);
    write_reg(mmfc_pkg::REG_DAMP, 32'd0);
    write_reg(mmfc_pkg::REG_MOTOR, 32'd0);
    write_reg(mmfc_pkg::REG_BASE, 32'h0000_0550);
    random_phase(250);

    drain();
    for (int r = 0; r < 5; r++)
      write_reg(mmfc_pkg::reg_idx_e'(r), $urandom_range(1, 32'h0100_0000));
    write_reg(mmfc_pkg::REG_MOTOR, $urandom_range(0, 15));
    write_reg(mmfc_pkg::REG_BASE, $urandom_range(0, 2047));
    random_phase(280);

    while (pending != 0) @(negedge clk);
    repeat (mmfc_pkg::LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/core/mmfc_pkg.sv
rtl/core/mmfc_qdiv.sv
rtl/core/mit_motor_frame_codec.sv
verif/mmfc_checker.sv
verif/tb_mit_motor_frame_codec.sv
